@@ rtl/core/pps_pkg.sv @@
`timescale 1ns / 1ps
package pps_pkg;

  // Default widths
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COLOR_BITS_DEF = 12;

  // Fixed field formats
  localparam int POINT_W    = 32;
  localparam int COEF_W     = 21;
  localparam int TRANS_FRAC = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;

  // Square root steps done in one pipeline stage
  localparam int ISQ_SPS = 4;

  typedef enum logic [1:0] {
    MODE_STRIPE   = 2'd0,
    MODE_GRADIENT = 2'd1,
    MODE_RING     = 2'd2,
    MODE_CHECKER  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_MODE = 3'd0,
    REG_COLOR_A      = 3'd1,
    REG_COLOR_B      = 3'd2,
    REG_MATRIX_ROW_X = 3'd3,
    REG_MATRIX_ROW_Y = 3'd4,
    REG_MATRIX_ROW_Z = 3'd5,
    REG_TRANSLATION  = 3'd6
  } reg_idx_t;

  // Transformed point between the transform and shading pipelines
  typedef struct packed {
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic signed [POINT_W-1:0] z;
  } coord_t;

endpackage

@@ rtl/core/procedural_pattern_shader.sv @@
// Procedural pattern shader: affine transform, then stripe/gradient/ring/checkers color.
// Pipeline: three transform stages, three shading stages, the root pipeline and the output flop.
// Throughput: one beat per cycle outside reset; every stage is a plain register, the root is 4 steps a stage.
// The receiver cannot stall; each result shows for exactly one cycle with out_valid.
// Reset (synchronous, rst_n low) empties the pipeline and loads the identity transform.
`timescale 1ns / 1ps
module procedural_pattern_shader #(
  parameter int FRAC_BITS  = pps_pkg::FRAC_BITS_DEF,
  parameter int COLOR_BITS = pps_pkg::COLOR_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [pps_pkg::POINT_W-1:0]   in_point_x,
  input  logic signed [pps_pkg::POINT_W-1:0]   in_point_y,
  input  logic signed [pps_pkg::POINT_W-1:0]   in_point_z,
  output logic                                 out_valid,
  output logic [COLOR_BITS-1:0]                out_red,
  output logic [COLOR_BITS-1:0]                out_green,
  output logic [COLOR_BITS-1:0]                out_blue,
  input  logic                                 cfg_we,
  input  logic [pps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pps_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import pps_pkg::*;

  localparam int ISQ_STAGES = (32 - FRAC_BITS + ISQ_SPS - 1) / ISQ_SPS;
  localparam int LATENCY    = 7 + ISQ_STAGES;
  localparam int CW         = 3 * COLOR_BITS;

  mode_t                 mode_r;
  logic [CW-1:0]         color_a_r, color_b_r;
  logic [CFG_DATA_W-1:0] row_x_r, row_y_r, row_z_r, trans_r;
  logic                  in_fire;
  coord_t                in_pt, xf_pt;
  logic                  xf_valid;
  logic [CW-1:0]         color;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_STRIPE;
      color_a_r <= '0;
      color_b_r <= '0;
      row_x_r   <= CFG_DATA_W'(1) << FRAC_BITS;
      row_y_r   <= CFG_DATA_W'(1) << (FRAC_BITS + COEF_W);
      row_z_r   <= CFG_DATA_W'(1) << (FRAC_BITS + 2 * COEF_W);
      trans_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_MODE: mode_r    <= mode_t'(cfg_data[1:0]);
        REG_COLOR_A:      color_a_r <= cfg_data[CW-1:0];
        REG_COLOR_B:      color_b_r <= cfg_data[CW-1:0];
        REG_MATRIX_ROW_X: row_x_r   <= cfg_data;
        REG_MATRIX_ROW_Y: row_y_r   <= cfg_data;
        REG_MATRIX_ROW_Z: row_z_r   <= cfg_data;
        REG_TRANSLATION:  trans_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept a beat every cycle outside reset
  assign busy    = !rst_n;
  assign in_fire = start && !busy;

  assign in_pt.x = in_point_x;
  assign in_pt.y = in_point_y;
  assign in_pt.z = in_point_z;

  pps_xform #(
    .FRAC_BITS (FRAC_BITS)
  ) u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_fire),
    .in_pt     (in_pt),
    .row_x     (row_x_r),
    .row_y     (row_y_r),
    .row_z     (row_z_r),
    .trans     (trans_r),
    .out_valid (xf_valid),
    .out_pt    (xf_pt)
  );

  pps_shade #(
    .FRAC_BITS  (FRAC_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (xf_valid),
    .in_pt     (xf_pt),
    .mode      (mode_r),
    .color_a   (color_a_r),
    .color_b   (color_b_r),
    .out_valid (out_valid),
    .out_color (color)
  );

  assign out_red   = color[0 +: COLOR_BITS];
  assign out_green = color[COLOR_BITS +: COLOR_BITS];
  assign out_blue  = color[2*COLOR_BITS +: COLOR_BITS];

  // Every accepted beat comes out after passing the whole pipeline
  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##LATENCY out_valid)
    else $error("accepted beat did not produce a result");

  // No result without a beat accepted at the pipeline's input
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_fire, LATENCY))
    else $error("result without accepted beat");

  // Reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

endmodule

@@ rtl/core/pps_xform.sv @@
`timescale 1ns / 1ps
module pps_xform #(
  parameter int FRAC_BITS = pps_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  pps_pkg::coord_t                    in_pt,
  input  logic [pps_pkg::CFG_DATA_W-1:0]     row_x,
  input  logic [pps_pkg::CFG_DATA_W-1:0]     row_y,
  input  logic [pps_pkg::CFG_DATA_W-1:0]     row_z,
  input  logic [pps_pkg::CFG_DATA_W-1:0]     trans,
  output logic                               out_valid,
  output pps_pkg::coord_t                    out_pt
);
  import pps_pkg::*;

  localparam int PROD_W = COEF_W + POINT_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int ACC_W  = SUM_W + 1;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  logic [CFG_DATA_W-1:0]       rows [3];
  logic signed [POINT_W-1:0]   pts  [3];

  logic signed [PROD_W-1:0]    prod_nxt [3][3];
  logic signed [PROD_W-1:0]    prod_r   [3][3];
  logic signed [SUM_W-1:0]     sum_nxt  [3];
  logic signed [SUM_W-1:0]     sum_r    [3];
  logic signed [POINT_W-1:0]   crd_nxt  [3];
  logic signed [POINT_W-1:0]   crd_r    [3];
  logic                        v1_r, v2_r, v3_r;

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_z;
  assign pts[0]  = in_pt.x;
  assign pts[1]  = in_pt.y;
  assign pts[2]  = in_pt.z;

  // Stage 1: nine coefficient products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r][c] = PROD_W'($signed(rows[r][COEF_W*c +: COEF_W])) * PROD_W'(pts[c]);
      end
    end
  end

  // Stage 2: row sums
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_nxt[r] = SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1]) + SUM_W'(prod_r[r][2]);
    end
  end

  // Stage 3: floor shift, add offset, saturate
  always_comb begin
    logic signed [ACC_W-1:0] sh;
    logic signed [ACC_W-1:0] ofs;
    logic signed [ACC_W-1:0] tot;
    for (int r = 0; r < 3; r++) begin
      sh  = ACC_W'(sum_r[r]) >>> FRAC_BITS;
      ofs = ACC_W'($signed(trans[COEF_W*r +: COEF_W])) <<< (FRAC_BITS - TRANS_FRAC);
      tot = sh + ofs;
      if (tot > SAT_HI) begin
        crd_nxt[r] = SAT_HI[POINT_W-1:0];
      end else if (tot < SAT_LO) begin
        crd_nxt[r] = SAT_LO[POINT_W-1:0];
      end else begin
        crd_nxt[r] = tot[POINT_W-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
    crd_r  <= crd_nxt;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_pt.x  = crd_r[0];
  assign out_pt.y  = crd_r[1];
  assign out_pt.z  = crd_r[2];

endmodule

@@ rtl/core/pps_isqrt.sv @@
`timescale 1ns / 1ps
module pps_isqrt #(
  parameter int FRAC_BITS = pps_pkg::FRAC_BITS_DEF,
  localparam int ISQ_RW     = 32 - FRAC_BITS,
  localparam int ISQ_STAGES = (ISQ_RW + pps_pkg::ISQ_SPS - 1) / pps_pkg::ISQ_SPS,
  localparam int ISQ_T      = ISQ_STAGES * pps_pkg::ISQ_SPS,
  localparam int N_W        = 2 * ISQ_T
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [N_W-1:0] in_n,
  output logic           out_valid,
  output logic           out_odd
);
  import pps_pkg::*;

  localparam int REM_W = ISQ_T + 3;

  logic [REM_W-1:0] rem_in   [ISQ_STAGES];
  logic [ISQ_T-1:0] root_in  [ISQ_STAGES];
  logic [N_W-1:0]   bits_in  [ISQ_STAGES];
  logic             v_in     [ISQ_STAGES];
  logic [REM_W-1:0] rem_nxt  [ISQ_STAGES];
  logic [ISQ_T-1:0] root_nxt [ISQ_STAGES];
  logic [N_W-1:0]   bits_nxt [ISQ_STAGES];
  logic [REM_W-1:0] rem_r    [ISQ_STAGES];
  logic [ISQ_T-1:0] root_r   [ISQ_STAGES];
  logic [N_W-1:0]   bits_r   [ISQ_STAGES];
  logic             v_r      [ISQ_STAGES];

  for (genvar s = 0; s < ISQ_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign rem_in[s]  = '0;
      assign root_in[s] = '0;
      assign bits_in[s] = in_n;
      assign v_in[s]    = in_valid;
    end else begin : g_next
      assign rem_in[s]  = rem_r[s-1];
      assign root_in[s] = root_r[s-1];
      assign bits_in[s] = bits_r[s-1];
      assign v_in[s]    = v_r[s-1];
    end

    // Restoring digit steps, two radicand bits each
    always_comb begin
      logic [REM_W-1:0] rem;
      logic [REM_W-1:0] trial;
      logic [ISQ_T-1:0] root;
      logic [N_W-1:0]   bits;
      rem  = rem_in[s];
      root = root_in[s];
      bits = bits_in[s];
      for (int k = 0; k < ISQ_SPS; k++) begin
        rem   = {rem[REM_W-3:0], bits[N_W-1 -: 2]};
        bits  = {bits[N_W-3:0], 2'b00};
        trial = REM_W'({root, 2'b01});
        if (rem >= trial) begin
          rem  = rem - trial;
          root = {root[ISQ_T-2:0], 1'b1};
        end else begin
          root = {root[ISQ_T-2:0], 1'b0};
        end
      end
      rem_nxt[s]  = rem;
      root_nxt[s] = root;
      bits_nxt[s] = bits;
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_nxt[s];
      root_r[s] <= root_nxt[s];
      bits_r[s] <= bits_nxt[s];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_in[s];
      end
    end
  end

  assign out_valid = v_r[ISQ_STAGES-1];
  assign out_odd   = root_r[ISQ_STAGES-1][0];

endmodule

@@ rtl/core/pps_shade.sv @@
`timescale 1ns / 1ps
module pps_shade #(
  parameter int FRAC_BITS  = pps_pkg::FRAC_BITS_DEF,
  parameter int COLOR_BITS = pps_pkg::COLOR_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  pps_pkg::coord_t           in_pt,
  input  pps_pkg::mode_t            mode,
  input  logic [3*COLOR_BITS-1:0]   color_a,
  input  logic [3*COLOR_BITS-1:0]   color_b,
  output logic                      out_valid,
  output logic [3*COLOR_BITS-1:0]   out_color
);
  import pps_pkg::*;

  localparam int ISQ_RW     = 32 - FRAC_BITS;
  localparam int ISQ_STAGES = (ISQ_RW + ISQ_SPS - 1) / ISQ_SPS;
  localparam int N_W        = 2 * ISQ_STAGES * ISQ_SPS;
  localparam int CW         = 3 * COLOR_BITS;
  localparam int GP_W       = COLOR_BITS + FRAC_BITS + 2;
  localparam int SQ_W       = 2 * POINT_W;

  // Stage A
  logic [POINT_W-1:0]   ax_r, az_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic                 par_a_r, va_r;
  // Stage B
  logic [SQ_W-1:0]      sqx_r, sqz_r;
  logic [CW-1:0]        grad_nxt, grad_b_r;
  logic                 par_b_r, vb_r;
  // Stage C
  logic [N_W-1:0]       n_r;
  logic [CW-1:0]        grad_c_r;
  logic                 par_c_r, vc_r;
  // Alignment with the root pipeline
  logic [CW-1:0]        dly_grad_r [ISQ_STAGES];
  logic                 dly_par_r  [ISQ_STAGES];
  logic                 root_valid, root_odd;
  // Output
  logic [CW-1:0]        color_nxt, color_r;
  logic                 pick_b;
  logic                 vo_r;
  logic [SQ_W-1:0]      sq_sum;

  // Gradient channels: a + (b - a) * frac, floor
  always_comb begin
    logic signed [COLOR_BITS:0] dif;
    logic signed [GP_W-1:0]     prod;
    logic signed [GP_W-1:0]     acc;
    for (int j = 0; j < 3; j++) begin
      dif  = $signed({1'b0, color_b[COLOR_BITS*j +: COLOR_BITS]})
           - $signed({1'b0, color_a[COLOR_BITS*j +: COLOR_BITS]});
      prod = GP_W'(dif) * GP_W'($signed({1'b0, frac_r}));
      acc  = $signed(GP_W'({color_a[COLOR_BITS*j +: COLOR_BITS], {FRAC_BITS{1'b0}}})) + prod;
      grad_nxt[COLOR_BITS*j +: COLOR_BITS] = acc[FRAC_BITS +: COLOR_BITS];
    end
  end

  assign sq_sum = sqx_r + sqz_r;

  // Front stages: abs and parity, squares and gradient, radicand
  always_ff @(posedge clk) begin
    ax_r     <= in_pt.x[POINT_W-1] ? POINT_W'(-in_pt.x) : POINT_W'(in_pt.x);
    az_r     <= in_pt.z[POINT_W-1] ? POINT_W'(-in_pt.z) : POINT_W'(in_pt.z);
    frac_r   <= in_pt.x[FRAC_BITS-1:0];
    par_a_r  <= (mode == MODE_STRIPE) ? in_pt.x[FRAC_BITS]
              : in_pt.x[FRAC_BITS] ^ in_pt.y[FRAC_BITS] ^ in_pt.z[FRAC_BITS];
    sqx_r    <= SQ_W'(ax_r) * SQ_W'(ax_r);
    sqz_r    <= SQ_W'(az_r) * SQ_W'(az_r);
    grad_b_r <= grad_nxt;
    par_b_r  <= par_a_r;
    n_r      <= N_W'(sq_sum >> (2 * FRAC_BITS));
    grad_c_r <= grad_b_r;
    par_c_r  <= par_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  // Ring: parity of the integer square root
  pps_isqrt #(
    .FRAC_BITS (FRAC_BITS)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vc_r),
    .in_n      (n_r),
    .out_valid (root_valid),
    .out_odd   (root_odd)
  );

  // Carry the other results alongside the root pipeline
  always_ff @(posedge clk) begin
    dly_grad_r[0] <= grad_c_r;
    dly_par_r[0]  <= par_c_r;
    for (int i = 1; i < ISQ_STAGES; i++) begin
      dly_grad_r[i] <= dly_grad_r[i-1];
      dly_par_r[i]  <= dly_par_r[i-1];
    end
  end

  // Final color select
  always_comb begin
    pick_b    = (mode == MODE_RING) ? root_odd : dly_par_r[ISQ_STAGES-1];
    color_nxt = pick_b ? color_b : color_a;
    if (mode == MODE_GRADIENT) begin
      color_nxt = dly_grad_r[ISQ_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    color_r <= color_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= root_valid;
    end
  end

  assign out_valid = vo_r;
  assign out_color = color_r;

endmodule

@@ dv/tb_procedural_pattern_shader.sv @@
`timescale 1ns / 1ps
module tb_procedural_pattern_shader;
  import pps_pkg::*;

  localparam int FRAC  = FRAC_BITS_DEF;
  localparam int CBITS = COLOR_BITS_DEF;
  localparam int SETTLE_CYCLES = 16;     // beyond the full pipeline
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [POINT_W-1:0] in_point_x = '0;
  logic signed [POINT_W-1:0] in_point_y = '0;
  logic signed [POINT_W-1:0] in_point_z = '0;
  logic out_valid;
  logic [CBITS-1:0] out_red, out_green, out_blue;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  procedural_pattern_shader u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the configuration
  mode_t       sh_mode = MODE_STRIPE;
  logic [35:0] sh_color_a = '0;
  logic [35:0] sh_color_b = '0;
  logic [62:0] sh_row_x = 63'd65536;
  logic [62:0] sh_row_y = 63'd137438953472;
  logic [62:0] sh_row_z = 63'd288230376151711744;
  logic [62:0] sh_trans = '0;

  logic [35:0] color_queue[$];   // expected {blue, green, red}
  int sender_idle_pct = 0;
  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;
  int stall_cycles = 0;

  // One row of the affine transform, floored and saturated
  function automatic longint xform(logic [62:0] row, logic [20:0] toff,
                                   logic signed [31:0] px, logic signed [31:0] py,
                                   logic signed [31:0] pz);
    longint s;
    s = longint'($signed(row[20:0])) * longint'(px)
      + longint'($signed(row[41:21])) * longint'(py)
      + longint'($signed(row[62:42])) * longint'(pz);
    s = s >>> FRAC;
    s = s + longint'($signed(toff)) * (longint'(1) << (FRAC - TRANS_FRAC));
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Expected color for one point under the shadow configuration
  function automatic logic [35:0] shade_point(logic signed [31:0] px,
                                              logic signed [31:0] py,
                                              logic signed [31:0] pz);
    longint x, y, z, a, b, v;
    longint unsigned ax, az, n;
    logic [35:0] res;
    logic pick_b;
    x = xform(sh_row_x, sh_trans[20:0], px, py, pz);
    y = xform(sh_row_y, sh_trans[41:21], px, py, pz);
    z = xform(sh_row_z, sh_trans[62:42], px, py, pz);
    pick_b = 1'b0;
    res = '0;
    if (sh_mode == MODE_GRADIENT) begin
      for (int j = 0; j < 3; j++) begin
        a = longint'(sh_color_a[CBITS*j +: CBITS]);
        b = longint'(sh_color_b[CBITS*j +: CBITS]);
        v = a * (longint'(1) << FRAC) + (b - a) * (x & ((longint'(1) << FRAC) - 1));
        res[CBITS*j +: CBITS] = v[FRAC +: CBITS];
      end
      return res;
    end
    case (sh_mode)
      MODE_STRIPE: pick_b = x[FRAC];
      MODE_RING: begin
        ax = (x < 0) ? -x : x;
        az = (z < 0) ? -z : z;
        n = (ax * ax + az * az) >> (2 * FRAC);
        pick_b = ((int_sqrt(n) & 64'd1) != 64'd0);
      end
      default: pick_b = x[FRAC] ^ y[FRAC] ^ z[FRAC];
    endcase
    return pick_b ? sh_color_b : sh_color_a;
  endfunction

  // Result checking
  always @(posedge clk) begin
    logic [35:0] exp_c;
    if (rst_n && out_valid) begin
      beats_out++;
      if (color_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %h %h %h", out_red, out_green, out_blue);
      end else begin
        exp_c = color_queue.pop_front();
        if (out_red !== exp_c[11:0] || out_green !== exp_c[23:12] ||
            out_blue !== exp_c[35:24]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("color mismatch: exp r/g/b %h %h %h, got %h %h %h",
                     exp_c[11:0], exp_c[23:12], exp_c[35:24],
                     out_red, out_green, out_blue);
        end
      end
    end
  end

  // Watchdog on cycles where no beat moves
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles > STALL_LIMIT) begin
        $display("tb_procedural_pattern_shader: done, errors");
        $finish;
      end
    end
  end

  task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    @(posedge clk);
    while (busy) @(posedge clk);
    color_queue.push_back(shade_point(px, py, pz));
    beats_in++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (color_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [62:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_PATTERN_MODE: sh_mode = mode_t'(val[1:0]);
      REG_COLOR_A:      sh_color_a = val[35:0];
      REG_COLOR_B:      sh_color_b = val[35:0];
      REG_MATRIX_ROW_X: sh_row_x = val;
      REG_MATRIX_ROW_Y: sh_row_y = val;
      REG_MATRIX_ROW_Z: sh_row_z = val;
      default:          sh_trans = val;
    endcase
  endtask

  // Full reload; data above the mode and color fields is set at random to check masking
  task automatic load_config(mode_t m, logic [35:0] ca, logic [35:0] cb,
                             logic [62:0] rx, logic [62:0] ry, logic [62:0] rz,
                             logic [62:0] tr);
    drain();
    write_reg(REG_PATTERN_MODE, {61'($urandom), m});
    write_reg(REG_COLOR_A, {27'($urandom), ca});
    write_reg(REG_COLOR_B, {27'($urandom), cb});
    write_reg(REG_MATRIX_ROW_X, rx);
    write_reg(REG_MATRIX_ROW_Y, ry);
    write_reg(REG_MATRIX_ROW_Z, rz);
    write_reg(REG_TRANSLATION, tr);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [62:0] pack3(logic [20:0] c0, logic [20:0] c1, logic [20:0] c2);
    return {c2, c1, c0};
  endfunction

  function automatic logic [20:0] rand_coef();
    if ($urandom_range(3) == 0) return 21'($urandom);
    return 21'($signed($urandom_range(262143)) - 131072);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2097151)) - 1048576);
      default: return 32'($signed($urandom_range(33554431)) - 16777216);
    endcase
  endfunction

  function automatic logic [35:0] rand_color();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return {4'($urandom), $urandom};
    endcase
  endfunction

  function automatic logic [62:0] rand_trans();
    if ($urandom_range(3) == 0) return {31'($urandom), $urandom};
    return pack3(21'($signed($urandom_range(8191)) - 4096),
                 21'($signed($urandom_range(8191)) - 4096),
                 21'($signed($urandom_range(8191)) - 4096));
  endfunction

  // Identity transform at reset, stripe mode with zero colors, then each mode, then extremes
  task automatic test_directed();
    logic [31:0] pts[6];
    pts = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF, 32'h00010000, 32'hFFFF0000};
    send_point(32'h0001_8000, 32'h0, 32'h0);
    send_point(32'hFFFF_8000, 32'h0, 32'h0);
    for (int m = 0; m < 4; m++) begin
      load_config(mode_t'(m), 36'h123456789, 36'hFEDCBA987,
                  pack3(21'h10000, 21'h0, 21'h0), pack3(21'h0, 21'h10000, 21'h0),
                  pack3(21'h0, 21'h0, 21'h10000), '0);
      for (int i = 0; i < 6; i++) send_point(pts[i], pts[5 - i], pts[(i + 2) % 6]);
    end
    // Saturation with extreme coefficients and translations
    load_config(MODE_RING, 36'h000FFF000, 36'hFFF000FFF,
                pack3(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF),
                pack3(21'h100000, 21'h100000, 21'h100000),
                pack3(21'h100000, 21'h0FFFFF, 21'h0), pack3(21'h0FFFFF, 21'h100000, 21'h0FFFFF));
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    send_point(32'h80000000, 32'h7FFFFFFF, 32'h00000001);
    load_config(MODE_GRADIENT, 36'hFFFFFFFFF, 36'h0, pack3(21'h10000, 21'h0, 21'h0),
                '0, '0, pack3(21'h100000, 21'h0, 21'h0));
    send_point(32'h0000FFFF, 32'h0, 32'h0);
    send_point(32'h7FFFFFFF, 32'h0, 32'h0);
    drain();
  endtask

  // Random configs, fifty random points each
  task automatic test_random(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0)
        load_config(mode_t'($urandom_range(3)), rand_color(), rand_color(),
                    pack3(rand_coef(), rand_coef(), rand_coef()),
                    pack3(rand_coef(), rand_coef(), rand_coef()),
                    pack3(rand_coef(), rand_coef(), rand_coef()), rand_trans());
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    sender_idle_pct = 23;
    test_random(450);
    sender_idle_pct = 84;
    test_random(450);
    sender_idle_pct = 0;
    test_random(450);
    $display("covered: %0d points in, %0d colors out, all four patterns", beats_in, beats_out);
    $display("saturating transforms, gradient extremes and three sender idle rates");
    if (mismatches == 0 && color_queue.size() == 0) begin
      $display("tb_procedural_pattern_shader: done, clean");
    end else begin
      $display("mismatches: %0d, missing: %0d", mismatches, color_queue.size());
      $display("tb_procedural_pattern_shader: done, errors");
    end
    $finish;
  end

endmodule
